@@ rtl/tmcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tmcs_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int CHANNEL_COUNT_DEF = 48;

  localparam int CFG_W     = 10;
  localparam int DELTA_W   = 8;
  localparam int CHANNEL_W = 8;
  localparam int BAND_W    = 3;

  localparam logic [CFG_W-1:0] X_RES_RST    = 10'd320;
  localparam logic [CFG_W-1:0] Y_RES_RST    = 10'd240;
  localparam logic [CFG_W-1:0] X_THR_RST    = 10'd130;
  localparam logic [CFG_W-1:0] Y_THR_RST    = 10'd200;
  localparam logic [CFG_W-1:0] CURSOR_X_RST = 10'd200;
  localparam logic [CFG_W-1:0] CURSOR_Y_RST = 10'd100;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    CFG_X_RES = 2'd0,
    CFG_Y_RES = 2'd1,
    CFG_X_THR = 2'd2,
    CFG_Y_THR = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    SWIPE_NONE  = 3'd0,
    SWIPE_LEFT  = 3'd1,
    SWIPE_RIGHT = 3'd2,
    SWIPE_UP    = 3'd3,
    SWIPE_DOWN  = 3'd4
  } swipe_t;

  typedef struct packed {
    logic                      command;
    logic [7:0]                status_byte;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic                      cursor_mode;
  } report_t;

  typedef struct packed {
    logic [CFG_W-1:0]     cursor_x;
    logic [CFG_W-1:0]     cursor_y;
    logic                 button_pressed;
    logic                 report_pending;
    swipe_t               swipe;
    logic [CHANNEL_W-1:0] channel_index;
  } result_t;

  // Control handed to every history cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  // Width of a signed sum over the newest depth-1 deltas.
  function automatic int sum_width(input int depth);
    return $clog2((depth - 1) * 128 + 1) + 1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tmcs_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One history slot: takes its neighbor's deltas on a shift, zeroes on a clear.
module tmcs_cell (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire tmcs_pkg::win_ctrl_t                      ctrl,
  input  wire logic signed [tmcs_pkg::DELTA_W-1:0]      din_x,
  input  wire logic signed [tmcs_pkg::DELTA_W-1:0]      din_y,
  output logic signed [tmcs_pkg::DELTA_W-1:0]           dout_x,
  output logic signed [tmcs_pkg::DELTA_W-1:0]           dout_y
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      dout_x <= '0;
      dout_y <= '0;
    end else if (ctrl.shift) begin
      dout_x <= din_x;
      dout_y <= din_y;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmcs_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Chain of history cells over the summed window plus running window sums.
// The oldest history entry never reaches a sum, so the chain stops one short.
module tmcs_window #(
  parameter int HISTORY_DEPTH = tmcs_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire tmcs_pkg::win_ctrl_t                      ctrl,
  input  wire logic signed [tmcs_pkg::DELTA_W-1:0]      new_x,
  input  wire logic signed [tmcs_pkg::DELTA_W-1:0]      new_y,
  output logic signed [tmcs_pkg::sum_width(HISTORY_DEPTH)-1:0] win_x,
  output logic signed [tmcs_pkg::sum_width(HISTORY_DEPTH)-1:0] win_y
);

  localparam int CELLS = HISTORY_DEPTH - 1;
  localparam int SUM_W = tmcs_pkg::sum_width(HISTORY_DEPTH);

  logic signed [tmcs_pkg::DELTA_W-1:0] cell_x [CELLS];
  logic signed [tmcs_pkg::DELTA_W-1:0] cell_y [CELLS];
  logic signed [SUM_W-1:0]             sum_x;
  logic signed [SUM_W-1:0]             sum_y;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      tmcs_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .din_x  (new_x),
        .din_y  (new_y),
        .dout_x (cell_x[i]),
        .dout_y (cell_y[i])
      );
    end else begin : g_body
      tmcs_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .din_x  (cell_x[i-1]),
        .din_y  (cell_y[i-1]),
        .dout_x (cell_x[i]),
        .dout_y (cell_y[i])
      );
    end
  end

  // Sum after the shift: the new delta comes in, the last cell drops out.
  assign win_x = sum_x + SUM_W'(new_x) - SUM_W'(cell_x[CELLS-1]);
  assign win_y = sum_y + SUM_W'(new_y) - SUM_W'(cell_y[CELLS-1]);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (ctrl.shift) begin
      sum_x <= win_x;
      sum_y <= win_y;
    end
  end

  a_clear_zeroes_sum: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (sum_x == 0 && sum_y == 0))
    else $error("window sum not zero after a swipe clear");

endmodule

`default_nettype wire

@@ rtl/touch_motion_cursor_and_swipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Touch motion block: cursor tracking and swipe detection with channel step.
// Input channel (report_valid/report_ready/report) carries one beat per touch
// report or clear command. Output channel (result_valid/result_ready/result)
// returns exactly one beat per input beat, in order.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block does not enforce this. Index 0/1 are X/Y
// resolution, 2/3 are X/Y swipe thresholds. A result beat appears in the
// cycle after its input beat is accepted, held in a single result register.
// Throughput is one beat per cycle while the receiver keeps up; the window sum
// is a running total in the window block, so the decision for each beat
// needs only one add/subtract and compare per axis. If the receiver stalls,
// the result register holds its beat and report_ready drops until that beat
// is taken; a new beat is accepted in the same cycle the waiting one leaves.
// Reset (rst, synchronous) restores the default registers, puts the cursor at
// 200/100, empties the button latch, zeroes the history and selects channel 0.
module touch_motion_cursor_and_swipe #(
  parameter int HISTORY_DEPTH = tmcs_pkg::HISTORY_DEPTH_DEF,
  parameter int CHANNEL_COUNT = tmcs_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [tmcs_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          report_valid,
  output logic                               report_ready,
  input  wire tmcs_pkg::report_t             report,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output tmcs_pkg::result_t                  result
);

  localparam int SUM_W = tmcs_pkg::sum_width(HISTORY_DEPTH);
  localparam int CMP_W = ((SUM_W > tmcs_pkg::CFG_W + 1) ? SUM_W : tmcs_pkg::CFG_W + 1) + 1;
  localparam int CW    = tmcs_pkg::CFG_W;
  localparam int CHW   = tmcs_pkg::CHANNEL_W;

  // Configuration registers.
  logic [CW-1:0] x_res;
  logic [CW-1:0] y_res;
  logic [CW-1:0] x_thr;
  logic [CW-1:0] y_thr;

  // Architectural state outside the history.
  logic [CW-1:0]  cursor_x_pos;
  logic [CW-1:0]  cursor_y_pos;
  logic           button_latch;
  logic           latch_full;
  logic [CHW-1:0] channel_now;

  logic [CW-1:0]  cursor_x_next;
  logic [CW-1:0]  cursor_y_next;
  logic           button_latch_next;
  logic           latch_full_next;
  logic [CHW-1:0] channel_next;

  logic                    accept;
  logic                    is_report;
  logic                    is_swipe_mode;
  tmcs_pkg::win_ctrl_t     win_ctrl;
  tmcs_pkg::swipe_t        swipe_kind;
  logic signed [SUM_W-1:0] win_x;
  logic signed [SUM_W-1:0] win_y;
  logic signed [CMP_W-1:0] sx;
  logic signed [CMP_W-1:0] sy;
  logic signed [CMP_W-1:0] tx;
  logic signed [CMP_W-1:0] ty;
  logic signed [8:0]       neg_dy;

  assign report_ready  = !result_valid || result_ready;
  assign accept        = report_valid && report_ready;
  assign is_report     = (report.command == tmcs_pkg::CMD_REPORT);
  assign is_swipe_mode = is_report && !report.cursor_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_res <= tmcs_pkg::X_RES_RST;
      y_res <= tmcs_pkg::Y_RES_RST;
      x_thr <= tmcs_pkg::X_THR_RST;
      y_thr <= tmcs_pkg::Y_THR_RST;
    end else if (cfg_we) begin
      case (tmcs_pkg::cfg_index_t'(cfg_index))
        tmcs_pkg::CFG_X_RES: x_res <= cfg_data;
        tmcs_pkg::CFG_Y_RES: y_res <= cfg_data;
        tmcs_pkg::CFG_X_THR: x_thr <= cfg_data;
        tmcs_pkg::CFG_Y_THR: y_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Swipe window: the cells shift on every swipe-mode report.
  assign win_ctrl.shift = accept && is_swipe_mode;
  assign win_ctrl.clear = accept && is_swipe_mode && (swipe_kind != tmcs_pkg::SWIPE_NONE);

  tmcs_window #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (win_ctrl),
    .new_x (report.delta_x),
    .new_y (report.delta_y),
    .win_x (win_x),
    .win_y (win_y)
  );

  assign sx = CMP_W'(win_x);
  assign sy = CMP_W'(win_y);
  assign tx = CMP_W'($signed({1'b0, x_thr}));
  assign ty = CMP_W'($signed({1'b0, y_thr}));

  // Left, right, up and down are tested in that order; thresholds are strict.
  always_comb begin
    swipe_kind = tmcs_pkg::SWIPE_NONE;
    if (is_swipe_mode) begin
      if (sx > tx) begin
        swipe_kind = tmcs_pkg::SWIPE_LEFT;
      end else if (sx < -tx) begin
        swipe_kind = tmcs_pkg::SWIPE_RIGHT;
      end else if (sy > ty) begin
        swipe_kind = tmcs_pkg::SWIPE_UP;
      end else if (sy < -ty) begin
        swipe_kind = tmcs_pkg::SWIPE_DOWN;
      end
    end
  end

  // Clamp pos+delta to 1 .. res-1, with the upper limit never below 1.
  function automatic logic [CW-1:0] clamp_axis(input logic [CW-1:0] pos,
                                               input logic signed [8:0] delta,
                                               input logic [CW-1:0] res);
    logic [CW-1:0]      hi;
    logic signed [11:0] v;
    hi = (res < CW'(2)) ? CW'(1) : res - CW'(1);
    v  = $signed({2'b00, pos}) + 12'(delta);
    if (v < 12'sd1) begin
      return CW'(1);
    end else if (v > $signed({2'b00, hi})) begin
      return hi;
    end else begin
      return v[CW-1:0];
    end
  endfunction

  // Channel step stays within its band of eight, then wraps by the count.
  function automatic logic [CHW-1:0] step_channel(input logic [CHW-1:0] ch,
                                                  input logic up_step);
    logic [tmcs_pkg::BAND_W-1:0] low;
    logic [CHW:0]                n;
    low = up_step ? ch[tmcs_pkg::BAND_W-1:0] + 3'd1 : ch[tmcs_pkg::BAND_W-1:0] - 3'd1;
    n   = {1'b0, ch[CHW-1:tmcs_pkg::BAND_W], low};
    if (n >= (CHW+1)'(CHANNEL_COUNT)) begin
      n = n - (CHW+1)'(CHANNEL_COUNT);
    end
    return n[CHW-1:0];
  endfunction

  assign neg_dy = -(9'(report.delta_y));

  always_comb begin
    cursor_x_next     = cursor_x_pos;
    cursor_y_next     = cursor_y_pos;
    button_latch_next = button_latch;
    latch_full_next   = latch_full;
    channel_next      = channel_now;
    if (!is_report) begin
      button_latch_next = 1'b0;
      latch_full_next   = 1'b0;
    end else begin
      if (!latch_full) begin
        button_latch_next = report.status_byte[0];
        latch_full_next   = 1'b1;
      end
      if (report.cursor_mode) begin
        cursor_x_next = clamp_axis(cursor_x_pos, 9'(report.delta_x), x_res);
        cursor_y_next = clamp_axis(cursor_y_pos, neg_dy, y_res);
      end else if (swipe_kind == tmcs_pkg::SWIPE_UP) begin
        channel_next = step_channel(channel_now, 1'b0);
      end else if (swipe_kind == tmcs_pkg::SWIPE_DOWN) begin
        channel_next = step_channel(channel_now, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x_pos <= tmcs_pkg::CURSOR_X_RST;
      cursor_y_pos <= tmcs_pkg::CURSOR_Y_RST;
      button_latch <= 1'b0;
      latch_full   <= 1'b0;
      channel_now  <= '0;
    end else if (accept) begin
      cursor_x_pos <= cursor_x_next;
      cursor_y_pos <= cursor_y_next;
      button_latch <= button_latch_next;
      latch_full   <= latch_full_next;
      channel_now  <= channel_next;
    end
  end

  // Result register: loaded with the state after the accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.cursor_x       <= cursor_x_next;
      result.cursor_y       <= cursor_y_next;
      result.button_pressed <= button_latch_next;
      result.report_pending <= latch_full_next;
      result.swipe          <= swipe_kind;
      result.channel_index  <= channel_next;
    end
  end

  a_clear_no_swipe: assert property (@(posedge clk) disable iff (rst)
    (accept && report.command == tmcs_pkg::CMD_CLEAR) |=>
      (result_valid && result.swipe == tmcs_pkg::SWIPE_NONE && !result.report_pending))
    else $error("clear command produced a swipe or kept the latch");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.cursor_x != '0 && result.cursor_y != '0))
    else $error("cursor left its lower limit");

  a_channel_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((CHW+1)'(result.channel_index) < (CHW+1)'(CHANNEL_COUNT)))
    else $error("channel index beyond channel count");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tmcs_pkg::*;

  localparam int HIST_DEPTH   = HISTORY_DEPTH_DEF;
  localparam int CHAN_COUNT   = CHANNEL_COUNT_DEF;
  localparam int PHASE_BEATS  = 310;
  localparam int SETTLE_LIMIT = 1000;

  // The tracker mirrors the block: it keeps its own copy of the cursor, the
  // button latch, the motion history, the channel and the four registers. Each
  // accepted input beat is run through it and the result it predicts waits in
  // a queue until the matching result beat leaves the block.
  class touch_tracker;
    logic [CFG_W-1:0]     x_res, y_res, x_thr, y_thr;
    logic [CFG_W-1:0]     cur_x, cur_y;
    logic                 btn, full;
    int                   x_hist [HIST_DEPTH];
    int                   y_hist [HIST_DEPTH];
    logic [CHANNEL_W-1:0] chan;
    result_t              expected_q [$];
    int                   fail_count;

    function new();
      x_res = X_RES_RST;
      y_res = Y_RES_RST;
      x_thr = X_THR_RST;
      y_thr = Y_THR_RST;
      cur_x = CURSOR_X_RST;
      cur_y = CURSOR_Y_RST;
      btn   = 1'b0;
      full  = 1'b0;
      chan  = '0;
      fail_count = 0;
      foreach (x_hist[i]) begin
        x_hist[i] = 0;
        y_hist[i] = 0;
      end
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_X_RES: x_res = value;
        CFG_Y_RES: y_res = value;
        CFG_X_THR: x_thr = value;
        CFG_Y_THR: y_thr = value;
        default: ;
      endcase
    endfunction

    // Move one axis and hold it inside 1 .. res-1; a resolution below two
    // pins the upper limit at 1.
    function logic [CFG_W-1:0] limit_axis(logic [CFG_W-1:0] pos, int delta,
                                          logic [CFG_W-1:0] res);
      int hi, v;
      hi = int'(res) - 1;
      if (hi < 1) hi = 1;
      v = int'(pos) + delta;
      if (v < 1) v = 1;
      else if (v > hi) v = hi;
      return v[CFG_W-1:0];
    endfunction

    // Step within the band of eight, then fold into the channel count.
    function void hop_channel(bit upward);
      int band, low, n;
      band = int'(chan) / 8;
      low  = int'(chan) % 8;
      if (upward) low = (low == 7) ? 0 : low + 1;
      else        low = (low == 0) ? 7 : low - 1;
      n = band * 8 + low;
      if (n >= CHAN_COUNT) n -= CHAN_COUNT;
      if (n < 0) n += CHAN_COUNT;
      chan = n[CHANNEL_W-1:0];
    endfunction

    // Push the deltas into the history, sum the newest depth-1 entries and
    // classify. X is tested before Y, and a hit wipes the summed entries
    // while the oldest one survives.
    function swipe_t window_swipe(int dx, int dy);
      int     sx, sy, tx, ty;
      swipe_t kind;
      sx = 0;
      sy = 0;
      tx = int'(x_thr);
      ty = int'(y_thr);
      kind = SWIPE_NONE;
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        x_hist[i] = x_hist[i-1];
        y_hist[i] = y_hist[i-1];
      end
      x_hist[0] = dx;
      y_hist[0] = dy;
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        sx += x_hist[i];
        sy += y_hist[i];
      end
      if (sx > tx) kind = SWIPE_LEFT;
      else if (sx < -tx) kind = SWIPE_RIGHT;
      else if (sy > ty) kind = SWIPE_UP;
      else if (sy < -ty) kind = SWIPE_DOWN;
      if (kind != SWIPE_NONE) begin
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
          x_hist[i] = 0;
          y_hist[i] = 0;
        end
      end
      return kind;
    endfunction

    function void take_report(report_t r);
      result_t want;
      swipe_t  kind;
      int      dx, dy;
      kind = SWIPE_NONE;
      dx = int'(r.delta_x);
      dy = int'(r.delta_y);
      if (r.command == CMD_CLEAR) begin
        btn  = 1'b0;
        full = 1'b0;
      end else begin
        if (!full) begin
          btn  = r.status_byte[0];
          full = 1'b1;
        end
        if (r.cursor_mode) begin
          cur_x = limit_axis(cur_x, dx, x_res);
          cur_y = limit_axis(cur_y, -dy, y_res);
        end else begin
          kind = window_swipe(dx, dy);
          if (kind == SWIPE_UP) hop_channel(1'b0);
          else if (kind == SWIPE_DOWN) hop_channel(1'b1);
        end
      end
      want.cursor_x       = cur_x;
      want.cursor_y       = cur_y;
      want.button_pressed = btn;
      want.report_pending = full;
      want.swipe          = kind;
      want.channel_index  = chan;
      expected_q.push_back(want);
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        fail_count++;
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no input beat waiting for it");
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      check_field("cursor_x", 16'(want.cursor_x), 16'(seen.cursor_x));
      check_field("cursor_y", 16'(want.cursor_y), 16'(seen.cursor_y));
      check_field("button_pressed", 16'(want.button_pressed), 16'(seen.button_pressed));
      check_field("report_pending", 16'(want.report_pending), 16'(seen.report_pending));
      check_field("swipe", 16'(want.swipe), 16'(seen.swipe));
      check_field("channel_index", 16'(want.channel_index), 16'(seen.channel_index));
    endfunction
  endclass

  // Every input starts at a known value; rst is high from time zero.
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  cfg_index_t   cfg_index = CFG_X_RES;
  logic [CFG_W-1:0] cfg_data = '0;
  logic         report_valid = 1'b0;
  logic         report_ready;
  report_t      report = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_t      result;

  // When steady is set neither side idles, which gives one long stretch of
  // back-to-back beats through the block.
  bit           steady = 1'b0;
  touch_tracker tracker = new();

  touch_motion_cursor_and_swipe DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver side. Everything the testbench drives changes through
  // nonblocking assignments, so the values read right after the edge are the
  // ones the block saw at that edge. An accepted result beat is handed to the
  // tracker; ready then stalls in about a third of the cycles unless steady.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) tracker.check_result(result);
      result_ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  function automatic report_t report_beat(logic cmd, logic [7:0] status, int dx, int dy,
                                          logic mode);
    report_t r;
    r.command     = cmd;
    r.status_byte = status;
    r.delta_x     = dx[7:0];
    r.delta_y     = dy[7:0];
    r.cursor_mode = mode;
    return r;
  endfunction

  // Sender side. Valid is only lowered when a gap is taken, so a beat that
  // follows straight on keeps valid high across the edge that took the
  // previous one. The beat counts as accepted at the first edge where ready
  // was high, and only then goes into the tracker.
  task automatic send_report(input report_t r);
    while (!steady && $urandom_range(99) < 35) begin
      report_valid <= 1'b0;
      @(posedge clk);
    end
    report_valid <= 1'b1;
    report       <= r;
    do @(posedge clk); while (!report_ready);
    tracker.take_report(r);
  endtask

  // Stop sending and wait for every predicted result beat to come back,
  // then give the result register a little extra time.
  task automatic settle();
    int waited;
    waited = 0;
    report_valid <= 1'b0;
    while (tracker.expected_q.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; the write enable stays
  // high through the burst and drops once at the end.
  task automatic program_regs(input logic [CFG_W-1:0] xr, input logic [CFG_W-1:0] yr,
                              input logic [CFG_W-1:0] xt, input logic [CFG_W-1:0] yt);
    logic [CFG_W-1:0] vals [4];
    cfg_index_t       regs [4];
    vals = '{xr, yr, xt, yt};
    regs = '{CFG_X_RES, CFG_Y_RES, CFG_X_THR, CFG_Y_THR};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      tracker.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int    sent, pick, len, main_d, cross_d;
    bit    vertical, negative;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset register values (resolution 320 x 240,
    // thresholds 130 and 200).
    // The first report fills the latch with the button set; the second one
    // shows the latch holding while full. Both hit the field extremes; the first
    // pushes X against its upper limit.
    send_report(report_beat(CMD_REPORT, 8'hFF, 127, -128, 1'b1));
    send_report(report_beat(CMD_REPORT, 8'hFE, -128, 127, 1'b1));
    // A clear drops the latch; the next report latches a released button.
    send_report(report_beat(CMD_CLEAR, 8'hFF, 127, 127, 1'b1));
    // Drive the cursor into the lower limit on both axes, then the upper.
    send_report(report_beat(CMD_REPORT, 8'h00, -128, 127, 1'b1));
    send_report(report_beat(CMD_REPORT, 8'h01, -128, 127, 1'b1));
    send_report(report_beat(CMD_REPORT, 8'h01, -128, 127, 1'b1));
    send_report(report_beat(CMD_REPORT, 8'h80, 127, -128, 1'b1));
    send_report(report_beat(CMD_REPORT, 8'h80, 127, -128, 1'b1));
    send_report(report_beat(CMD_REPORT, 8'h80, 127, -128, 1'b1));
    // Left swipe on the second beat.
    send_report(report_beat(CMD_REPORT, 8'h00, 127, 0, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 127, 0, 1'b0));
    // A sum equal to the threshold is not a swipe; one more count is.
    send_report(report_beat(CMD_REPORT, 8'h00, 65, 0, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 65, 0, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 1, 0, 1'b0));
    // Right swipe.
    send_report(report_beat(CMD_REPORT, 8'h00, -128, 0, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, -128, 0, 1'b0));
    // Up swipe steps the channel down and wraps inside the first band.
    send_report(report_beat(CMD_REPORT, 8'h00, 0, 127, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 0, 127, 1'b0));
    // Two down swipes: wrap back to zero, then step up.
    send_report(report_beat(CMD_REPORT, 8'h00, 0, -128, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 0, -128, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 0, -128, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 0, -128, 1'b0));
    // X and Y both past their thresholds: left wins.
    send_report(report_beat(CMD_REPORT, 8'h00, 127, 127, 1'b0));
    send_report(report_beat(CMD_REPORT, 8'h00, 127, 127, 1'b0));

    // Random phases, each under its own register setting. Each starts from a
    // drained block, so the sender pauses until every result is back.
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: program_regs(10'd1023, 10'd1023, 10'd0, 10'd0);
        1: program_regs(10'd2, 10'd2, 10'd1023, 10'd1023);
        2: program_regs(X_RES_RST, Y_RES_RST, X_THR_RST, Y_THR_RST);
        // Resolutions below two pin the cursor at 1.
        3: program_regs(10'd1, 10'd0, 10'd300, 10'd50);
        4: program_regs(CFG_W'($urandom_range(1023, 2)),
                        CFG_W'($urandom_range(1023, 2)),
                        CFG_W'($urandom_range(500)),
                        CFG_W'($urandom_range(500)));
        default: program_regs(10'd640, 10'd480, 10'd100, 10'd100);
      endcase
      steady = (p == 2);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 52) begin
          // A gesture: a short run of reports moving one way along one axis,
          // with some jitter on the other axis.
          len      = $urandom_range(7, 2);
          vertical = 1'($urandom_range(1));
          negative = 1'($urandom_range(1));
          repeat (len) begin
            if (negative) main_d = 0 - int'($urandom_range(128, 20));
            else          main_d = $urandom_range(127, 20);
            cross_d = int'($urandom_range(60)) - 30;
            if (vertical)
              send_report(report_beat(CMD_REPORT, 8'($urandom), cross_d, main_d, 1'b0));
            else
              send_report(report_beat(CMD_REPORT, 8'($urandom), main_d, cross_d, 1'b0));
            sent++;
          end
        end else if (pick < 60) begin
          send_report(report_beat(CMD_CLEAR, 8'($urandom), $urandom, $urandom,
                                  1'($urandom)));
          sent++;
        end else if (pick < 88) begin
          send_report(report_beat(CMD_REPORT, 8'($urandom), $urandom, $urandom, 1'b1));
          sent++;
        end else begin
          send_report(report_t'($urandom));
          sent++;
        end
      end
      steady = 1'b0;
    end

    settle();
    if (tracker.expected_q.size() != 0) begin
      $error("%0d result beats never arrived", tracker.expected_q.size());
      tracker.fail_count++;
    end
    if (tracker.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ touch_motion_cursor_and_swipe.f @@
rtl/tmcs_pkg.sv
rtl/tmcs_cell.sv
rtl/tmcs_window.sv
rtl/touch_motion_cursor_and_swipe.sv
tb/sv/tb.sv
